// ===== src/sdmd_pkg.sv =====
package sdmd_pkg;

  localparam int PIX_W       = 8;
  localparam int INDEX_W     = 17;
  localparam int NF_W        = 3;
  localparam int TARGET_W    = PIX_W + NF_W;
  localparam int WORD_W      = 2 * PIX_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - INDEX_W - 3 * PIX_W;
  localparam int IN_PAD_W    = IN_TDATA_W - INDEX_W - PIX_W;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_N_FACTOR = 2'd0;
  localparam reg_idx_t REG_V_MIN    = 2'd1;
  localparam reg_idx_t REG_V_MAX    = 2'd2;

  localparam logic [NF_W-1:0]  N_FACTOR_RESET = 3'd3;
  localparam logic [PIX_W-1:0] V_MIN_RESET    = 8'd1;
  localparam logic [PIX_W-1:0] V_MAX_RESET    = 8'd254;

  typedef struct packed {
    logic [PIX_W-1:0] spread;
    logic [PIX_W-1:0] mean;
  } bg_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               motion;
    logic [PIX_W-1:0]   diff;
    logic [PIX_W-1:0]   mean;
    logic [PIX_W-1:0]   spread;
  } result_t;

endpackage

// ===== src/sdmd_ram.sv =====
module sdmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sigma_delta_motion_detect.sv =====
// Sigma-delta background subtraction on a stream of grey pixels.
// Input stream: in_tdata carries the pixel and its raster index, in_tuser
// flags an initialization frame that loads mean from the pixel and spread
// from v_min. Output stream: one result per input with the index echoed,
// the motion flag in out_tuser, and the difference, mean and spread.
// Mean and spread of every pixel sit together in one on-chip memory of
// PIXEL_DEPTH 16-bit words, addressed by the index modulo PIXEL_DEPTH
// (a power of two). The memory needs no clearing; each pixel must see an
// initialization frame before its first normal frame.
// Path: the memory read and the update stage registers are loaded at the input
// transfer edge; the update goes into the output register when that register
// is empty or draining, so an output stall can hold it in the update stage.
// Throughput: one pixel per clock while out_tready is high; a write-back to
// the same entry as the next read is forwarded, so repeated indices also run
// at full rate. When the receiver stalls the result holds in the output
// register, one more pixel may still be taken into the update stage, then
// in_tready drops until the output drains.
// Reset clears the pipeline valids and loads n_factor 3, v_min 1, v_max 254. The user
// must write registers over the APB port only while idle; the block does not enforce it.
module sigma_delta_motion_detect
  import sdmd_pkg::*;
#(
  parameter int PIXEL_DEPTH = 131072
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pixel, pixel_index
  input  logic [0:0]             in_tuser,   // init_frame
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_index, abs_difference, background, spread
  output logic [0:0]             out_tuser,  // motion
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int AW = $clog2(PIXEL_DEPTH);

  // configuration
  logic [NF_W-1:0]  n_factor_r;
  logic [PIX_W-1:0] v_min_r;
  logic [PIX_W-1:0] v_max_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_factor_r <= N_FACTOR_RESET;
      v_min_r    <= V_MIN_RESET;
      v_max_r    <= V_MAX_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_N_FACTOR: n_factor_r <= cfg_pwdata[NF_W-1:0];
        REG_V_MIN:    v_min_r    <= cfg_pwdata[PIX_W-1:0];
        REG_V_MAX:    v_max_r    <= cfg_pwdata[PIX_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_N_FACTOR: cfg_prdata = CFG_DATA_W'(n_factor_r);
      REG_V_MIN:    cfg_prdata = CFG_DATA_W'(v_min_r);
      REG_V_MAX:    cfg_prdata = CFG_DATA_W'(v_max_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // input unpacking
  logic [PIX_W-1:0]   in_pixel;
  logic [INDEX_W-1:0] in_index;
  logic               in_init;
  logic [AW-1:0]      in_addr;
  logic               in_xfer;

  assign in_pixel = in_tdata[PIX_W-1:0];
  assign in_index = in_tdata[PIX_W+INDEX_W-1:PIX_W];
  assign in_init  = in_tuser[0];
  assign in_addr  = AW'(in_index);

  // update stage
  logic               s1_valid_r;
  logic [PIX_W-1:0]   s1_pixel_r;
  logic [INDEX_W-1:0] s1_index_r;
  logic [AW-1:0]      s1_addr_r;
  logic               s1_init_r;
  logic               fwd_r;
  bg_word_t           fwd_word_r;
  logic               out_valid_r;
  result_t            out_r;
  logic               out_load;
  bg_word_t           ram_rdata;
  bg_word_t           old_word;
  bg_word_t           new_word;
  result_t            res;

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  sdmd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PIXEL_DEPTH)
  ) u_bg_ram (
    .clk   (clk),
    .we    (out_load),
    .waddr (s1_addr_r),
    .wdata (new_word),
    .re    (in_xfer),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  assign old_word = fwd_r ? fwd_word_r : ram_rdata;

  logic [PIX_W-1:0]    mean_step;
  logic [PIX_W-1:0]    diff;
  logic [TARGET_W-1:0] target;
  logic [PIX_W:0]      sp_step;
  logic [PIX_W:0]      sp_hi;
  logic [PIX_W:0]      sp_clamp;

  always_comb begin
    if (old_word.mean < s1_pixel_r) begin
      mean_step = old_word.mean + 8'd1;
    end else if (old_word.mean > s1_pixel_r) begin
      mean_step = old_word.mean - 8'd1;
    end else begin
      mean_step = old_word.mean;
    end

    diff   = (mean_step > s1_pixel_r) ? (mean_step - s1_pixel_r) : (s1_pixel_r - mean_step);
    target = TARGET_W'(n_factor_r) * TARGET_W'(diff);

    if (TARGET_W'(old_word.spread) < target) begin
      sp_step = {1'b0, old_word.spread} + 9'd1;
    end else if (TARGET_W'(old_word.spread) > target) begin
      sp_step = {1'b0, old_word.spread} - 9'd1;
    end else begin
      sp_step = {1'b0, old_word.spread};
    end

    sp_hi    = (sp_step > {1'b0, v_max_r}) ? {1'b0, v_max_r} : sp_step;
    sp_clamp = (sp_hi < {1'b0, v_min_r}) ? {1'b0, v_min_r} : sp_hi;

    res.index = s1_index_r;
    if (s1_init_r) begin
      res.mean   = s1_pixel_r;
      res.spread = v_min_r;
      res.diff   = '0;
      res.motion = 1'b0;
    end else begin
      res.mean   = mean_step;
      res.spread = sp_clamp[PIX_W-1:0];
      res.diff   = diff;
      res.motion = !(diff < sp_clamp[PIX_W-1:0]);
    end

    new_word.mean   = res.mean;
    new_word.spread = res.spread;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= out_load && (s1_addr_r == in_addr);
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pixel_r <= in_pixel;
      s1_index_r <= in_index;
      s1_addr_r  <= in_addr;
      s1_init_r  <= in_init;
      fwd_word_r <= new_word;
    end
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_r.motion;
  assign out_tdata    = {OUT_PAD_W'(0), out_r.spread, out_r.mean, out_r.diff, out_r.index};

  // checks
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted pixel did not reach update stage");

  a_forward_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && out_load && (s1_addr_r == in_addr)) |=> fwd_r)
    else $error("write-back to same entry not forwarded");

  a_no_forward_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !(out_load && (s1_addr_r == in_addr))) |=> !fwd_r)
    else $error("forward taken without matching write-back");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |=> (s1_valid_r && $stable(s1_addr_r)))
    else $error("update stage lost during output stall");

endmodule
